FILE: hw/rtl/txcon_pkg.sv
package txcon_pkg;

    // Coordinate width: columns use COORD_BITS, rows one bit more
    localparam int COORD_BITS = 10;

    // Display command codes
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_CLEAR  = 2'd0;
    localparam cmd_t CMD_SCROLL = 2'd1;
    localparam cmd_t CMD_GLYPH  = 2'd2;

    // Character codes with special handling
    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    // Configuration register indexes
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_CHAR_WIDTH     = 2'd0;
    localparam reg_idx_t REG_CHAR_HEIGHT    = 2'd1;
    localparam reg_idx_t REG_DISPLAY_WIDTH  = 2'd2;
    localparam reg_idx_t REG_DISPLAY_HEIGHT = 2'd3;

    // Configuration reset values
    localparam logic [6:0] RST_CHAR_WIDTH     = 7'd12;
    localparam logic [6:0] RST_CHAR_HEIGHT    = 7'd16;
    localparam logic [9:0] RST_DISPLAY_WIDTH  = 10'd240;
    localparam logic [9:0] RST_DISPLAY_HEIGHT = 10'd320;

endpackage

FILE: hw/rtl/text_console_hw_scroll_cursor.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------------------
// input     | in_valid / in_stall    | char_code
// output    | out_valid / out_stall  | command pos_x pos_y rect_width area_height
//           |                        | scroll_line glyph last
// config    | cfg_write              | cfg_index cfg_data
//
// Carriage return: idle only. Line feed: HOME. Drawn character: HOME, WRAP, ROOM,
// then DIV, PART, SCROLL, YROW on a scroll (no DIV with zero display height), then
// ROWCLR, GLYPH. Scroll start modulo: restoring divider, one dividend bit per cycle.
// Reset (rst_n, async low) clears cursor and scroll state and reloads config defaults.
// Output stalls hold the sequencer at the next command; input is taken only when idle.
module text_console_hw_scroll_cursor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  command,
    output logic [9:0]  pos_x,
    output logic [10:0] pos_y,
    output logic [9:0]  rect_width,
    output logic [6:0]  area_height,
    output logic [9:0]  scroll_line,
    output logic [7:0]  glyph,
    output logic        last,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int CB        = txcon_pkg::COORD_BITS;
    localparam int SB        = (CB > 10) ? CB : 10;
    localparam int DIV_STEPS = CB + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HOME   = 4'd1;
    localparam logic [3:0] ST_WRAP   = 4'd2;
    localparam logic [3:0] ST_ROOM   = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_PART   = 4'd5;
    localparam logic [3:0] ST_SCROLL = 4'd6;
    localparam logic [3:0] ST_YROW   = 4'd7;
    localparam logic [3:0] ST_ROWCLR = 4'd8;
    localparam logic [3:0] ST_GLYPH  = 4'd9;

    typedef struct packed {
        logic                 req;
        txcon_pkg::cmd_t      cmd;
        logic [9:0]           x;
        logic [10:0]          y;
        logic [9:0]           w;
        logic [6:0]           h;
        logic [9:0]           line;
        logic [7:0]           g;
        logic                 lst;
    } emit_t;

    // Configuration registers
    logic [6:0] cw_reg, ch_reg;
    logic [9:0] dw_reg, dh_reg;

    // Console state
    logic [CB-1:0] col_reg, col_next;
    logic [CB:0]   row_reg, row_next;
    logic [CB:0]   prev_reg, prev_next;
    logic          scrl_reg, scrl_next;
    logic [CB-1:0] sstart_reg, sstart_next;

    // Sequencer and divider
    logic [3:0]       state_reg, state_next;
    logic [7:0]       char_reg, char_next;
    logic [CB:0]      dvd_reg, dvd_next;
    logic [9:0]       rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SB-1:0]    s_reg, s_next;

    // Output register
    logic            out_valid_reg, out_valid_next;
    txcon_pkg::cmd_t command_reg;
    logic [9:0]      pos_x_reg, rect_width_reg, scroll_line_reg;
    logic [10:0]     pos_y_reg;
    logic [6:0]      area_height_reg;
    logic [7:0]      glyph_reg;
    logic            last_reg;

    emit_t emit;
    logic  slot_free, fire;

    // Datapath helpers
    logic [CB+1:0]        row_sum;
    logic [CB:0]          row_adv;
    logic                 wrap_need, no_fit;
    logic                 is_lf, home, row_changed;
    logic [10:0]          rem_sh, rem_sub;
    logic                 rem_ge;
    logic                 s_small;
    logic [6:0]           part;
    logic signed [11:0]   py;
    logic [10:0]          py_clamp;
    logic signed [CB+1:0] y0, y1;
    logic [CB:0]          y_row;

    assign row_sum = {1'b0, row_reg} + (CB+2)'(ch_reg);
    assign row_adv = row_sum[CB+1] ? '1 : row_sum[CB:0];

    assign wrap_need = (CB+2)'(dw_reg) < ((CB+2)'(col_reg) + (CB+2)'(cw_reg));
    assign no_fit    = (CB+2)'(dh_reg) < ((CB+2)'(row_reg) + (CB+2)'(ch_reg));

    assign is_lf       = (char_reg == txcon_pkg::CHAR_LF);
    assign home        = (col_reg == '0) && (row_reg == '0);
    assign row_changed = (prev_reg != row_reg);

    // Restoring divider step: one dividend bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[CB]};
    assign rem_ge  = rem_sh >= {1'b0, dh_reg};
    assign rem_sub = rem_ge ? (rem_sh - {1'b0, dh_reg}) : rem_sh;

    // Partial line at the bottom of scroll memory
    assign s_small  = (rem_reg != '0) && (rem_reg < 10'(ch_reg));
    assign part     = ch_reg - rem_reg[6:0];
    assign py       = $signed({2'b00, dh_reg}) - $signed({5'b0, part});
    assign py_clamp = py[11] ? '0 : py[10:0];

    // Row of the new bottom line after a scroll
    assign y0    = $signed({2'b00, sstart_reg}) - $signed((CB+2)'(ch_reg));
    assign y1    = y0[CB+1] ? (y0 + $signed((CB+2)'(dh_reg))) : y0;
    assign y_row = y1[CB+1] ? '0 : y1[CB:0];

    assign slot_free = !out_valid_reg || !out_stall;
    assign fire      = emit.req && slot_free;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        char_next   = char_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        prev_next   = prev_reg;
        scrl_next   = scrl_reg;
        sstart_next = sstart_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        s_next      = s_reg;

        emit      = '0;
        emit.cmd  = txcon_pkg::CMD_CLEAR;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    char_next = char_code;
                    if (char_code != txcon_pkg::CHAR_CR)
                        state_next = ST_HOME;
                end
            end
            ST_HOME:
            begin
                if (home)
                begin
                    emit.req = 1'b1;
                    emit.w   = dw_reg;
                    emit.h   = ch_reg;
                    emit.lst = is_lf;
                end
                if (!home || fire)
                begin
                    if (is_lf)
                    begin
                        row_next   = row_adv;
                        col_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WRAP;
                    end
                end
            end
            ST_WRAP:
            begin
                if (wrap_need)
                begin
                    row_next = row_adv;
                    col_next = '0;
                end
                state_next = ST_ROOM;
            end
            ST_ROOM:
            begin
                if (row_changed && (scrl_reg || no_fit))
                begin
                    scrl_next = 1'b1;
                    dvd_next  = {1'b0, sstart_reg} + (CB+1)'(ch_reg);
                    rem_next  = '0;
                    cnt_next  = CNT_W'(DIV_STEPS);
                    state_next = (dh_reg == '0) ? ST_PART : ST_DIV;
                end
                else
                begin
                    state_next = ST_ROWCLR;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_sub[9:0];
                dvd_next = {dvd_reg[CB-1:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_PART;
            end
            ST_PART:
            begin
                if (s_small)
                begin
                    emit.req = 1'b1;
                    emit.y   = py_clamp;
                    emit.w   = dw_reg;
                    emit.h   = part;
                    if (fire)
                    begin
                        s_next     = SB'(ch_reg);
                        state_next = ST_SCROLL;
                    end
                end
                else
                begin
                    s_next     = SB'(rem_reg);
                    state_next = ST_SCROLL;
                end
            end
            ST_SCROLL:
            begin
                emit.req  = 1'b1;
                emit.cmd  = txcon_pkg::CMD_SCROLL;
                emit.line = s_reg[CB-1:0];
                if (fire)
                begin
                    sstart_next = s_reg[CB-1:0];
                    state_next  = ST_YROW;
                end
            end
            ST_YROW:
            begin
                row_next   = y_row;
                state_next = ST_ROWCLR;
            end
            ST_ROWCLR:
            begin
                if (row_changed)
                begin
                    emit.req = 1'b1;
                    emit.y   = row_reg;
                    emit.w   = dw_reg;
                    emit.h   = ch_reg;
                end
                if (!row_changed || fire)
                    state_next = ST_GLYPH;
            end
            ST_GLYPH:
            begin
                emit.req = 1'b1;
                emit.cmd = txcon_pkg::CMD_GLYPH;
                emit.x   = col_reg;
                emit.y   = row_reg;
                emit.w   = 10'(cw_reg);
                emit.h   = ch_reg;
                emit.g   = char_reg;
                emit.lst = 1'b1;
                if (fire)
                begin
                    col_next   = col_reg + CB'(cw_reg);
                    prev_next  = row_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Output valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            prev_reg      <= '0;
            scrl_reg      <= 1'b0;
            sstart_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            prev_reg      <= prev_next;
            scrl_reg      <= scrl_next;
            sstart_reg    <= sstart_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= txcon_pkg::RST_CHAR_WIDTH;
            ch_reg <= txcon_pkg::RST_CHAR_HEIGHT;
            dw_reg <= txcon_pkg::RST_DISPLAY_WIDTH;
            dh_reg <= txcon_pkg::RST_DISPLAY_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                txcon_pkg::REG_CHAR_WIDTH:     cw_reg <= cfg_data[6:0];
                txcon_pkg::REG_CHAR_HEIGHT:    ch_reg <= cfg_data[6:0];
                txcon_pkg::REG_DISPLAY_WIDTH:  dw_reg <= cfg_data;
                txcon_pkg::REG_DISPLAY_HEIGHT: dh_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        s_reg    <= s_next;
        if (fire)
        begin
            command_reg     <= emit.cmd;
            pos_x_reg       <= emit.x;
            pos_y_reg       <= emit.y;
            rect_width_reg  <= emit.w;
            area_height_reg <= emit.h;
            scroll_line_reg <= emit.line;
            glyph_reg       <= emit.g;
            last_reg        <= emit.lst;
        end
    end

    assign out_valid   = out_valid_reg;
    assign command     = command_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign rect_width  = rect_width_reg;
    assign area_height = area_height_reg;
    assign scroll_line = scroll_line_reg;
    assign glyph       = glyph_reg;
    assign last        = last_reg;

endmodule

FILE: hw/rtl/txcon_checker.sv
module txcon_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  command,
    input logic [9:0]  pos_x,
    input logic [10:0] pos_y,
    input logic [9:0]  rect_width,
    input logic [7:0]  glyph,
    input logic        last
);

    // A stalled transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(command) && $stable(pos_y)
            && $stable(glyph) && $stable(last))
        else $error("output transaction changed while stalled");

    // Only the three defined commands appear
    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (command == txcon_pkg::CMD_CLEAR) || (command == txcon_pkg::CMD_SCROLL)
            || (command == txcon_pkg::CMD_GLYPH))
        else $error("undefined command code");

    // Scroll command carries no position, size or glyph
    a_scroll_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (command == txcon_pkg::CMD_SCROLL)
            |-> (pos_x == '0) && (pos_y == '0) && (rect_width == '0) && (glyph == '0))
        else $error("scroll command with nonzero fields");

    // A glyph always closes its character
    a_glyph_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (command == txcon_pkg::CMD_GLYPH) |-> last)
        else $error("glyph command not marked last");

    // A scroll is always followed by more commands of the same character
    a_scroll_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (command == txcon_pkg::CMD_SCROLL) |-> !last)
        else $error("scroll command marked last");

endmodule

bind text_console_hw_scroll_cursor txcon_checker u_txcon_checker (.*);

FILE: bench/tb_text_console_hw_scroll_cursor.sv
module tb_text_console_hw_scroll_cursor;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 40;    // well past the slowest character (scroll path)
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 28;
    localparam int DIR_ROWS        = 35;

    // Short names for the package codes used in the table
    localparam logic [7:0]          CR_CODE = txcon_pkg::CHAR_CR;
    localparam logic [7:0]          LF_CODE = txcon_pkg::CHAR_LF;
    localparam txcon_pkg::reg_idx_t IDX_CW  = txcon_pkg::REG_CHAR_WIDTH;
    localparam txcon_pkg::reg_idx_t IDX_CH  = txcon_pkg::REG_CHAR_HEIGHT;
    localparam txcon_pkg::reg_idx_t IDX_DW  = txcon_pkg::REG_DISPLAY_WIDTH;
    localparam txcon_pkg::reg_idx_t IDX_DH  = txcon_pkg::REG_DISPLAY_HEIGHT;

    // One display command as it leaves the block
    typedef struct packed {
        txcon_pkg::cmd_t command;
        logic [9:0]      pos_x;
        logic [10:0]     pos_y;
        logic [9:0]      rect_width;
        logic [6:0]      area_height;
        logic [9:0]      scroll_line;
        logic [7:0]      glyph;
        logic            last;
    } disp_cmd_t;

    typedef enum logic {DIR_CHAR, DIR_REG} dir_kind_t;

    // Directed row: a character or a register write, with optional hand-typed results
    typedef struct packed {
        dir_kind_t           kind;
        logic [7:0]          code;
        txcon_pkg::reg_idx_t idx;
        logic [9:0]          value;
        logic                typed;
        logic [1:0]          n_typed;
        disp_cmd_t           r0;
        disp_cmd_t           r1;
    } dir_row_t;

    localparam disp_cmd_t NO_CMD     = '0;
    localparam disp_cmd_t HOME_CLEAR =
        '{txcon_pkg::CMD_CLEAR, 10'd0, 11'd0, 10'd240, 7'd16, 10'd0, 8'd0, 1'b1};
    localparam disp_cmd_t ROW1_CLEAR =
        '{txcon_pkg::CMD_CLEAR, 10'd0, 11'd16, 10'd240, 7'd16, 10'd0, 8'd0, 1'b0};
    localparam disp_cmd_t GLYPH_A    =
        '{txcon_pkg::CMD_GLYPH, 10'd0, 11'd16, 10'd12, 7'd16, 10'd0, 8'd65, 1'b1};
    localparam disp_cmd_t GLYPH_FF   =
        '{txcon_pkg::CMD_GLYPH, 10'd12, 11'd16, 10'd12, 7'd16, 10'd0, 8'd255, 1'b1};
    localparam disp_cmd_t GLYPH_00   =
        '{txcon_pkg::CMD_GLYPH, 10'd24, 11'd16, 10'd12, 7'd16, 10'd0, 8'd0, 1'b1};

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // default geometry right after reset
        '{DIR_CHAR, CR_CODE, IDX_CW, 10'd0, 1'b1, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, LF_CODE, IDX_CW, 10'd0, 1'b1, 2'd1, HOME_CLEAR, NO_CMD},
        '{DIR_CHAR, 8'd65,   IDX_CW, 10'd0, 1'b1, 2'd2, ROW1_CLEAR, GLYPH_A},
        '{DIR_CHAR, 8'd255,  IDX_CW, 10'd0, 1'b1, 2'd1, GLYPH_FF, NO_CMD},
        '{DIR_CHAR, 8'd0,    IDX_CW, 10'd0, 1'b1, 2'd1, GLYPH_00, NO_CMD},
        '{DIR_CHAR, 8'd127,  IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd128,  IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, CR_CODE, IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, LF_CODE, IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd90,   IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        // tiny display: immediate scroll, partial line at the bottom of scroll memory
        '{DIR_REG,  8'd0,    IDX_CW, 10'd8,  1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_REG,  8'd0,    IDX_CH, 10'd16, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_REG,  8'd0,    IDX_DW, 10'd16, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_REG,  8'd0,    IDX_DH, 10'd40, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd97,   IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd98,   IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd99,   IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, LF_CODE, IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd100,  IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd101,  IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, LF_CODE, IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd102,  IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd103,  IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd104,  IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        // cell wider and taller than the display
        '{DIR_REG,  8'd0,    IDX_CW, 10'd64, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_REG,  8'd0,    IDX_CH, 10'd64, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_REG,  8'd0,    IDX_DW, 10'd40, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_REG,  8'd0,    IDX_DH, 10'd40, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd48,   IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd49,   IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd50,   IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        // zero display height: scroll start wraps to 0
        '{DIR_REG,  8'd0,    IDX_DH, 10'd0,  1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd51,   IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, LF_CODE, IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD},
        '{DIR_CHAR, 8'd52,   IDX_CW, 10'd0, 1'b0, 2'd0, NO_CMD, NO_CMD}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          char_code = 8'd0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          command;
    logic [9:0]          pos_x;
    logic [10:0]         pos_y;
    logic [9:0]          rect_width;
    logic [6:0]          area_height;
    logic [9:0]          scroll_line;
    logic [7:0]          glyph;
    logic                last;
    logic                cfg_write = 1'b0;
    txcon_pkg::reg_idx_t cfg_index = IDX_CW;
    logic [9:0]          cfg_data = 10'd0;

    // Console geometry and cursor as the predictor sees them
    int chr_w  = txcon_pkg::RST_CHAR_WIDTH;
    int chr_h  = txcon_pkg::RST_CHAR_HEIGHT;
    int disp_w = txcon_pkg::RST_DISPLAY_WIDTH;
    int disp_h = txcon_pkg::RST_DISPLAY_HEIGHT;
    int cur_col = 0;
    int cur_row = 0;
    int prev_row = 0;
    int scroll_start = 0;
    bit scrolling = 1'b0;

    disp_cmd_t pending_cmds[$];

    int  errors = 0;
    int  cycle_count = 0;
    int  chars_sent = 0;
    int  live_chars = 0;
    int  reg_writes = 0;
    int  cmds_checked = 0;
    int  clears_seen = 0;
    int  scrolls_seen = 0;
    int  glyphs_seen = 0;
    bit  console_busy = 1'b0;
    bit  no_gaps = 1'b0;
    bit  hold_request = 1'b0;

    text_console_hw_scroll_cursor u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .command     (command),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_width  (rect_width),
        .area_height (area_height),
        .scroll_line (scroll_line),
        .glyph       (glyph),
        .last        (last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Queue one predicted command
    task automatic emit_cmd(input bit record, input txcon_pkg::cmd_t cmd, input int x,
                            input int y, input int w, input int h, input int line,
                            input logic [7:0] g);
        disp_cmd_t c;
        c.command     = cmd;
        c.pos_x       = x[9:0];
        c.pos_y       = y[10:0];
        c.rect_width  = w[9:0];
        c.area_height = h[6:0];
        c.scroll_line = line[9:0];
        c.glyph       = g;
        c.last        = 1'b0;
        if (record)
            pending_cmds.push_back(c);
    endtask

    function automatic int next_row(input int row);
        int v;
        v = row + chr_h;
        return (v > 2047) ? 2047 : v;
    endfunction

    // Place one character on the console: update cursor/scroll, predict its commands
    task automatic place_char(input logic [7:0] c, input bit record);
        int  n;
        bit  room;
        int  s;
        int  part;
        int  py;
        int  y;
        n = 0;
        room = 1'b1;
        if (c == CR_CODE)
            return;

        // home position clears the first text row
        if (cur_col == 0 && cur_row == 0)
        begin
            emit_cmd(record, txcon_pkg::CMD_CLEAR, 0, 0, disp_w, chr_h, 0, 8'd0);
            n++;
        end

        if (c == LF_CODE)
        begin
            cur_row = next_row(cur_row);
            cur_col = 0;
            if (record && n > 0)
                pending_cmds[pending_cmds.size() - 1].last = 1'b1;
            return;
        end

        // wrap at the right edge (signed test)
        if (disp_w - cur_col < chr_w)
        begin
            cur_row = next_row(cur_row);
            cur_col = 0;
        end

        if (prev_row != cur_row)
        begin
            if (scrolling)
                room = 1'b0;
            else if (disp_h - cur_row < chr_h)
            begin
                room = 1'b0;
                scrolling = 1'b1;
            end
        end

        // hardware scroll by one text line, skipping a partial line
        if (!room)
        begin
            s = scroll_start + chr_h;
            s = (disp_h == 0) ? 0 : s % disp_h;
            if (s > 0 && s < chr_h)
            begin
                part = chr_h - s;
                py = disp_h - part;
                if (py < 0)
                    py = 0;
                emit_cmd(record, txcon_pkg::CMD_CLEAR, 0, py, disp_w, part, 0, 8'd0);
                n++;
                s = chr_h;
            end
            scroll_start = s & 'h3FF;
            emit_cmd(record, txcon_pkg::CMD_SCROLL, 0, 0, 0, 0, scroll_start, 8'd0);
            n++;
            y = scroll_start - chr_h;
            if (y < 0)
                y += disp_h;
            if (y < 0)
                y = 0;
            cur_row = y;
        end

        if (prev_row != cur_row)
        begin
            emit_cmd(record, txcon_pkg::CMD_CLEAR, 0, cur_row, disp_w, chr_h, 0, 8'd0);
            n++;
        end

        emit_cmd(record, txcon_pkg::CMD_GLYPH, cur_col, cur_row, chr_w, chr_h, 0, c);
        if (record)
            pending_cmds[pending_cmds.size() - 1].last = 1'b1;

        cur_col = (cur_col + chr_w) & 'h3FF;
        prev_row = cur_row;
    endtask

    // Offer one character; predict once the transaction is taken
    task automatic send_char(input logic [7:0] c, input bit record = 1'b1);
        while (!no_gaps && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        console_busy = 1'b1;
        chars_sent++;
        if (c != CR_CODE)
            live_chars++;
        place_char(c, record);
    endtask

    // Register write; waits for the console to drain first
    task automatic write_reg(input txcon_pkg::reg_idx_t idx, input int v);
        if (console_busy)
        begin
            in_valid <= 1'b0;
            while (pending_cmds.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            console_busy = 1'b0;
        end
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[9:0];
        @(posedge clk);
        case (idx)
            IDX_CW:  chr_w  = v & 'h7F;
            IDX_CH:  chr_h  = v & 'h7F;
            IDX_DW:  disp_w = v & 'h3FF;
            IDX_DH:  disp_h = v & 'h3FF;
            default: ;
        endcase
        reg_writes++;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Geometry per random phase: first the extremes, then random ones
    task automatic random_setup(input int phase);
        int cw;
        int ch;
        int dw;
        int dh;
        case (phase)
            0: begin cw = 1;  ch = 1;  dw = 1023; dh = 1023; end
            1: begin cw = 64; ch = 64; dw = 1023; dh = 1023; end
            2: begin cw = 1;  ch = 64; dw = 64;   dh = 64;   end
            3: begin cw = 64; ch = 1;  dw = 1;    dh = 1;    end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    cw = $urandom_range(1, 64);
                    ch = $urandom_range(1, 64);
                    dw = $urandom_range(1, 1023);
                    dh = $urandom_range(1, 1023);
                end
                else
                begin
                    cw = $urandom_range(1, 24);
                    ch = $urandom_range(1, 32);
                    dw = $urandom_range(cw, 1023);
                    dh = $urandom_range(ch, 400);
                end
            end
        endcase
        write_reg(IDX_CW, cw);
        write_reg(IDX_CH, ch);
        write_reg(IDX_DW, dw);
        write_reg(IDX_DH, dh);
    endtask

    function automatic void cmp_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compare a taken command against the oldest prediction
    task automatic check_cmd();
        disp_cmd_t want;
        if (pending_cmds.size() == 0)
        begin
            $error("command %0d arrived with nothing outstanding", command);
            errors++;
            return;
        end
        want = pending_cmds.pop_front();
        cmds_checked++;
        case (command)
            txcon_pkg::CMD_CLEAR:  clears_seen++;
            txcon_pkg::CMD_SCROLL: scrolls_seen++;
            txcon_pkg::CMD_GLYPH:  glyphs_seen++;
            default: ;
        endcase
        cmp_field("command", want.command, command);
        cmp_field("pos_x", want.pos_x, pos_x);
        cmp_field("pos_y", want.pos_y, pos_y);
        cmp_field("rect_width", want.rect_width, rect_width);
        cmp_field("area_height", want.area_height, area_height);
        cmp_field("scroll_line", want.scroll_line, scroll_line);
        cmp_field("glyph", want.glyph, glyph);
        cmp_field("last", want.last, last);
    endtask

    // Command sink with random stalls and one long hold-off
    initial
    begin : cmd_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_cmd();
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !no_gaps && ($urandom_range(0, 99) < 38);
        end
    end

    // Watchdog
    initial
    begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("text_console_hw_scroll_cursor: mismatch");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        int phase;
        int start;
        int k;
        int len;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIRECTED[i].kind == DIR_REG)
                write_reg(DIRECTED[i].idx, DIRECTED[i].value);
            else
            begin
                send_char(DIRECTED[i].code, !DIRECTED[i].typed);
                if (DIRECTED[i].typed && DIRECTED[i].n_typed > 0)
                    pending_cmds.push_back(DIRECTED[i].r0);
                if (DIRECTED[i].typed && DIRECTED[i].n_typed > 1)
                    pending_cmds.push_back(DIRECTED[i].r1);
            end
        end

        // random phases: mostly text lines, some line-feed runs, raw noise and carriage-return runs
        for (phase = 0; phase < PHASES; phase++)
        begin
            random_setup(phase);
            no_gaps = (phase == 6);
            if (phase == 4)
                hold_request = 1'b1;
            start = live_chars;
            while (live_chars - start < ITEMS_PER_PHASE)
            begin
                k = $urandom_range(0, 9);
                if (k <= 5)
                begin
                    len = $urandom_range(1, 30);
                    repeat (len) send_char(8'($urandom_range(32, 126)));
                    if ($urandom_range(0, 1) == 1)
                        send_char(CR_CODE);
                    send_char(LF_CODE);
                end
                else if (k == 6)
                begin
                    len = $urandom_range(1, 40);
                    repeat (len) send_char(LF_CODE);
                end
                else if (k <= 8)
                begin
                    len = $urandom_range(1, 8);
                    repeat (len) send_char(8'($urandom_range(0, 255)));
                end
                else
                begin
                    len = $urandom_range(1, 3);
                    repeat (len) send_char(CR_CODE);
                    send_char(8'($urandom_range(0, 255)));
                end
            end
        end
        no_gaps = 1'b0;
        in_valid <= 1'b0;

        // drain
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d characters through %0d register writes, %0d commands checked.",
                 chars_sent, reg_writes, cmds_checked);
        $display("Seen: %0d clears, %0d scroll updates, %0d glyphs, %0d errors.",
                 clears_seen, scrolls_seen, glyphs_seen, errors);
        if (errors == 0)
            $display("text_console_hw_scroll_cursor: match");
        else
            $display("text_console_hw_scroll_cursor: mismatch");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/txcon_pkg.sv
hw/rtl/text_console_hw_scroll_cursor.sv
hw/rtl/txcon_checker.sv
bench/tb_text_console_hw_scroll_cursor.sv
